// ===== rtl/core/gn3d_pkg.sv =====
package gn3d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int OUT_W     = 16;
    localparam int CELL_W    = 8;
    localparam int T_W       = 16;
    localparam int ONE_Q16   = 65536;

    // Offsets are Q1.16 (18 bits signed), gradients Q2.16 (20 bits signed).
    localparam int OFS_W  = 18;
    localparam int GRAD_W = 20;
    localparam int LERP_W = 22;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [T_W-1:0]    t_frac;

    function automatic t_cell perm_rom(input t_cell idx);
        logic [7:0] tbl [256];
        tbl = '{
        8'h97,8'ha0,8'h89,8'h5b,8'h5a,8'h0f,8'h83,8'h0d,8'hc9,8'h5f,8'h60,8'h35,8'hc2,8'he9,8'h07,8'he1,
        8'h8c,8'h24,8'h67,8'h1e,8'h45,8'h8e,8'h08,8'h63,8'h25,8'hf0,8'h15,8'h0a,8'h17,8'hbe,8'h06,8'h94,
        8'hf7,8'h78,8'hea,8'h4b,8'h00,8'h1a,8'hc5,8'h3e,8'h5e,8'hfc,8'hdb,8'hcb,8'h75,8'h23,8'h0b,8'h20,
        8'h39,8'hb1,8'h21,8'h58,8'hed,8'h95,8'h38,8'h57,8'hae,8'h14,8'h7d,8'h88,8'hab,8'ha8,8'h44,8'haf,
        8'h4a,8'ha5,8'h47,8'h86,8'h8b,8'h30,8'h1b,8'ha6,8'h4d,8'h92,8'h9e,8'he7,8'h53,8'h6f,8'he5,8'h7a,
        8'h3c,8'hd3,8'h85,8'he6,8'hdc,8'h69,8'h5c,8'h29,8'h37,8'h2e,8'hf5,8'h28,8'hf4,8'h66,8'h8f,8'h36,
        8'h41,8'h19,8'h3f,8'ha1,8'h01,8'hd8,8'h50,8'h49,8'hd1,8'h4c,8'h84,8'hbb,8'hd0,8'h59,8'h12,8'ha9,
        8'hc8,8'hc4,8'h87,8'h82,8'h74,8'hbc,8'h9f,8'h56,8'ha4,8'h64,8'h6d,8'hc6,8'had,8'hba,8'h03,8'h40,
        8'h34,8'hd9,8'he2,8'hfa,8'h7c,8'h7b,8'h05,8'hca,8'h26,8'h93,8'h76,8'h7e,8'hff,8'h52,8'h55,8'hd4,
        8'hcf,8'hce,8'h3b,8'he3,8'h2f,8'h10,8'h3a,8'h11,8'hb6,8'hbd,8'h1c,8'h2a,8'hdf,8'hb7,8'haa,8'hd5,
        8'h77,8'hf8,8'h98,8'h02,8'h2c,8'h9a,8'ha3,8'h46,8'hdd,8'h99,8'h65,8'h9b,8'ha7,8'h2b,8'hac,8'h09,
        8'h81,8'h16,8'h27,8'hfd,8'h13,8'h62,8'h6c,8'h6e,8'h4f,8'h71,8'he0,8'he8,8'hb2,8'hb9,8'h70,8'h68,
        8'hda,8'hf6,8'h61,8'he4,8'hfb,8'h22,8'hf2,8'hc1,8'hee,8'hd2,8'h90,8'h0c,8'hbf,8'hb3,8'ha2,8'hf1,
        8'h51,8'h33,8'h91,8'heb,8'hf9,8'h0e,8'hef,8'h6b,8'h31,8'hc0,8'hd6,8'h1f,8'hb5,8'hc7,8'h6a,8'h9d,
        8'hb8,8'h54,8'hcc,8'hb0,8'h73,8'h79,8'h32,8'h2d,8'h7f,8'h04,8'h96,8'hfe,8'h8a,8'hec,8'hcd,8'h5d,
        8'hde,8'h72,8'h43,8'h1d,8'h18,8'h48,8'hf3,8'h8d,8'h80,8'hc3,8'h4e,8'h42,8'hd7,8'h3d,8'h9c,8'hb4};
        return tbl[idx];
    endfunction

    function automatic t_frac frac_of(input logic [COORD_W-1:0] raw);
        logic [T_W+FRAC_BITS-1:0] ext;
        ext = {raw[FRAC_BITS-1:0], {T_W{1'b0}}};
        return ext[T_W+FRAC_BITS-1 -: T_W];
    endfunction

    function automatic t_cell cell_of(input logic [COORD_W-1:0] raw);
        return raw[FRAC_BITS +: CELL_W];
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [3:0] h,
        input logic signed [OFS_W-1:0] dx,
        input logic signed [OFS_W-1:0] dy,
        input logic signed [OFS_W-1:0] dz);
        logic signed [GRAD_W-1:0] a, b;
        a = (h < 4'd8) ? GRAD_W'(dx) : GRAD_W'(dy);
        b = (h < 4'd4) ? GRAD_W'(dy) :
            ((h == 4'd12 || h == 4'd14) ? GRAD_W'(dx) : GRAD_W'(dz));
        if (h[0]) a = -a;
        if (h[1]) b = -b;
        return a + b;
    endfunction

    // a + floor(((b - a) * w + 2^15) / 2^16); w is 0..65536.
    function automatic logic signed [LERP_W-1:0] blend(
        input logic signed [LERP_W-1:0] a,
        input logic signed [LERP_W-1:0] b,
        input logic [16:0] w);
        logic signed [LERP_W+19:0] p;
        p = (LERP_W+20)'(b - a) * $signed({1'b0, w}) + (LERP_W+20)'(32768);
        return a + LERP_W'(p >>> 16);
    endfunction

endpackage

// ===== rtl/core/gradient_noise_3d.sv =====
// Improved gradient noise over a 256-cell lattice.
// s_axis: one 3D point per word, tdata = {z, y, x}, each signed with 16 fraction
// bits. m_axis: one noise word per point, signed Q2.14.
// Depth: 9 register stages. Throughput: one word per cycle while the output is
// not stalled, set by the fully pipelined fade, hash and blend stages.
// The pipeline advances as one unit: when the output register holds a word the
// receiver has not taken, all stages hold and s_axis_tready drops, so nothing is
// lost or repeated. Empty stages are not removed during a stall, but tready
// stays high while the output is empty or being taken.
// Reset clears all valid bits; data registers are not reset.
// Stages: 1-5 fade powers and ROM hash levels, 6 gradients, 7 x blend,
// 8 y blend, 9 z blend and rounding into the output register.
module gradient_noise_3d
    import gn3d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // point_x[31:0], point_y[63:32], point_z[95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // noise_value[15:0]
);
    localparam int DEPTH = 9;

    logic             w_en;
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      w_px, w_py, w_pz;
    logic [16:0]      w_u, w_v, w_w;
    logic [3:0]       w_h [8];

    t_frac r_fx [5];
    t_frac r_fy [5];
    t_frac r_fz [5];
    logic signed [GRAD_W-1:0] r_g [8];
    logic signed [LERP_W-1:0] r_lx [4];
    logic signed [LERP_W-1:0] r_ly [2];
    logic [16:0] r_v1, r_w1, r_w2;
    logic [16:0] r_u1, r_v2, r_w1a;
    logic [15:0] r_out;
    logic signed [LERP_W-1:0] n_lz;
    logic signed [LERP_W-1:0] n_r;
    logic signed [OFS_W-1:0] w_x0, w_y0, w_z0, w_x1, w_y1, w_z1;

    assign w_px = s_axis_tdata[31:0];
    assign w_py = s_axis_tdata[63:32];
    assign w_pz = s_axis_tdata[95:64];

    assign w_en          = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    gn3d_fade u_fx (.i_clk, .i_en(w_en), .i_t(frac_of(w_px)), .o_fade(w_u));
    gn3d_fade u_fy (.i_clk, .i_en(w_en), .i_t(frac_of(w_py)), .o_fade(w_v));
    gn3d_fade u_fz (.i_clk, .i_en(w_en), .i_t(frac_of(w_pz)), .o_fade(w_w));

    gn3d_hash u_hash (
        .i_clk, .i_en(w_en),
        .i_cx(cell_of(w_px)), .i_cy(cell_of(w_py)), .i_cz(cell_of(w_pz)),
        .o_h(w_h)
    );

    // Fractions travel alongside the five fade stages.
    assign w_x0 = $signed({2'b0, r_fx[4]});
    assign w_y0 = $signed({2'b0, r_fy[4]});
    assign w_z0 = $signed({2'b0, r_fz[4]});
    assign w_x1 = w_x0 - OFS_W'(ONE_Q16);
    assign w_y1 = w_y0 - OFS_W'(ONE_Q16);
    assign w_z1 = w_z0 - OFS_W'(ONE_Q16);

    always_comb begin
        n_lz = blend(r_ly[0], r_ly[1], r_w2);
        n_r  = (n_lz + LERP_W'(2)) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx[0] <= frac_of(w_px);
            r_fy[0] <= frac_of(w_py);
            r_fz[0] <= frac_of(w_pz);
            for (int i = 1; i < 5; i++) begin
                r_fx[i] <= r_fx[i-1];
                r_fy[i] <= r_fy[i-1];
                r_fz[i] <= r_fz[i-1];
            end
            // Stage 6: gradients. Fade and hash outputs are both 5 deep here.
            r_g[0] <= grad(w_h[0], w_x0, w_y0, w_z0);
            r_g[1] <= grad(w_h[1], w_x1, w_y0, w_z0);
            r_g[2] <= grad(w_h[2], w_x0, w_y1, w_z0);
            r_g[3] <= grad(w_h[3], w_x1, w_y1, w_z0);
            r_g[4] <= grad(w_h[4], w_x0, w_y0, w_z1);
            r_g[5] <= grad(w_h[5], w_x1, w_y0, w_z1);
            r_g[6] <= grad(w_h[6], w_x0, w_y1, w_z1);
            r_g[7] <= grad(w_h[7], w_x1, w_y1, w_z1);
            r_v1 <= w_v;
            r_w1 <= w_w;
            // Stage 7 needs u one stage later; fade u is held in its own chain.
            for (int i = 0; i < 4; i++) begin
                r_lx[i] <= blend(LERP_W'(r_g[2*i]), LERP_W'(r_g[2*i+1]), r_u1);
            end
            r_ly[0] <= blend(r_lx[0], r_lx[1], r_v2);
            r_ly[1] <= blend(r_lx[2], r_lx[3], r_v2);
            r_w2    <= r_w1a;
            if (n_r > LERP_W'(32767))
                r_out <= 16'h7fff;
            else if (n_r < -LERP_W'(32768))
                r_out <= 16'h8000;
            else
                r_out <= n_r[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u1  <= w_u;
            r_v2  <= r_v1;
            r_w1a <= r_w1;
        end
    end
endmodule

// ===== rtl/core/gn3d_fade.sv =====
module gn3d_fade
    import gn3d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_frac       i_t,
    output logic [16:0] o_fade
);
    // Five-stage power chain; stages 1-4 each do one 17x17 multiply, stage 5 the sum.
    logic [16:0] r_t   [3];
    logic [16:0] r_t2, r_t3, r_t4, r_t5;
    logic [16:0] r_t3b, r_t3c, r_t4b;
    logic signed [21:0] r_sum;
    logic signed [21:0] n_sum;

    function automatic logic [16:0] rnd(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] p;
        p = a * b + 34'd32768;
        return p[32:16];
    endfunction

    always_comb begin
        n_sum = 22'sd10 * $signed({5'd0, r_t3c}) - 22'sd15 * $signed({5'd0, r_t4b})
              + 22'sd6 * $signed({5'd0, r_t5});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= {1'b0, i_t};
            r_t[1] <= r_t[0];
            r_t[2] <= r_t[1];
            r_t2   <= rnd({1'b0, i_t}, {1'b0, i_t});
            r_t3   <= rnd(r_t2, r_t[0]);
            r_t4   <= rnd(r_t3, r_t[1]);
            r_t3b  <= r_t3;
            r_t5   <= rnd(r_t4, r_t[2]);
            r_t4b  <= r_t4;
            r_t3c  <= r_t3b;
            r_sum  <= n_sum;
        end
    end

    assign o_fade = (r_sum < 0) ? 17'd0 :
                    (r_sum > 22'sd65536) ? 17'd65536 : r_sum[16:0];
endmodule

// ===== rtl/core/gn3d_hash.sv =====
module gn3d_hash
    import gn3d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cell      i_cx,
    input  t_cell      i_cy,
    input  t_cell      i_cz,
    output logic [3:0] o_h [8]
);
    // Three ROM levels, one per stage; o_h order: aa,ba,ab,bb, then the +1 z row.
    // Two more stages delay the hashes so they line up with the fade outputs.
    t_cell r_a, r_b, r_cz1;
    t_cell r_aa, r_ab, r_ba, r_bb;
    t_cell w_p [8];
    logic [3:0] r_h [8];
    logic [3:0] r_hd1 [8];
    logic [3:0] r_hd2 [8];

    assign w_p[0] = perm_rom(r_aa);
    assign w_p[1] = perm_rom(r_ba);
    assign w_p[2] = perm_rom(r_ab);
    assign w_p[3] = perm_rom(r_bb);
    assign w_p[4] = perm_rom(r_aa + 8'd1);
    assign w_p[5] = perm_rom(r_ba + 8'd1);
    assign w_p[6] = perm_rom(r_ab + 8'd1);
    assign w_p[7] = perm_rom(r_bb + 8'd1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= perm_rom(i_cx) + i_cy;
            r_b   <= perm_rom(i_cx + 8'd1) + i_cy;
            r_cz1 <= i_cz;
            r_aa  <= perm_rom(r_a) + r_cz1;
            r_ab  <= perm_rom(r_a + 8'd1) + r_cz1;
            r_ba  <= perm_rom(r_b) + r_cz1;
            r_bb  <= perm_rom(r_b + 8'd1) + r_cz1;
            for (int i = 0; i < 8; i++) begin
                r_h[i]   <= w_p[i][3:0];
                r_hd1[i] <= r_h[i];
                r_hd2[i] <= r_hd1[i];
            end
        end
    end
    assign o_h = r_hd2;
endmodule

// ===== rtl/core/gn3d_checker.sv =====
module gn3d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline stalled");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind gradient_noise_3d gn3d_checker u_chk (.*);
